>>> hdl/bsrc_pkg.sv
// Shared constants, types and codes for the banker's safety request check unit.
package bsrc_pkg;
  localparam int MAX_PROCS = 8;
  localparam int MAX_RES   = 8;
  localparam int PID_W     = 3;
  localparam int RES_W     = 3;
  localparam int CNT_W     = 4;
  localparam int WORK_W    = 12;
  localparam logic [WORK_W-1:0] WORK_MAX = {WORK_W{1'b1}};

  localparam logic [2:0] OP_AVAIL = 3'd0;
  localparam logic [2:0] OP_MAX   = 3'd1;
  localparam logic [2:0] OP_ALLOC = 3'd2;
  localparam logic [2:0] OP_REQ   = 3'd3;
  localparam logic [2:0] OP_CHECK = 3'd4;

  localparam logic [2:0] ST_WRITTEN = 3'd0;
  localparam logic [2:0] ST_GRANTED = 3'd1;
  localparam logic [2:0] ST_CLAIM   = 3'd2;
  localparam logic [2:0] ST_UNAVAIL = 3'd3;
  localparam logic [2:0] ST_DENIED  = 3'd4;
  localparam logic [2:0] ST_SAFE    = 3'd5;
  localparam logic [2:0] ST_UNSAFE  = 3'd6;
  localparam logic [2:0] ST_BAD     = 3'd7;

  localparam logic CFG_PROCS = 1'b0;
  localparam logic CFG_RES   = 1'b1;

  typedef struct packed {
    logic [7:0] maxc;
    logic [7:0] alloc;
  } cell_t;

  typedef cell_t [MAX_RES-1:0] row_t;

  typedef struct packed {
    logic             we;
    logic [PID_W-1:0] waddr;
    row_t             wdata;
    logic             re;
    logic [PID_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    if (v > CNT_W'(8)) r = CNT_W'(8);
    return r;
  endfunction
endpackage

>>> hdl/bsrc_row_mem.sv
// Per-process row memory holding maximum claim and allocation of every resource.
module bsrc_row_mem
  import bsrc_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output row_t     rdata_o
);
  row_t mem [MAX_PROCS];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_o <= mem[req_i.raddr];
    end
  end
endmodule

>>> hdl/bankers_safety_request_check_unit.sv
// Top level of the banker's safety request check unit.
// A safety scan reads each process row in turn through the single read port of the row memory;
// a safe sequence then leaves at one word per cycle while out_stall_i is low.
// One item is worked on at a time; the next is taken once all results are in the output register.
// Reset sets the process and resource counts to 8 and clears the available and request tables and
// the scan and output control; the row memory reads as zero because a sweep after reset clears all
// 8 rows before any input is taken.
module bankers_safety_request_check_unit
  import bsrc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] operation_i,
  input  logic [2:0] process_id_i,
  input  logic [2:0] resource_index_i,
  input  logic [7:0] amount_i,
  input  logic       last_element_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_o,
  output logic [2:0] sequence_process_o,
  output logic [2:0] sequence_position_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [3:0] cfg_data_i
);
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_WRMOD  = 4'd2;
  localparam logic [3:0] S_REQCHK = 4'd3;
  localparam logic [3:0] S_SCINIT = 4'd4;
  localparam logic [3:0] S_SCRD   = 4'd5;
  localparam logic [3:0] S_SCEV   = 4'd6;
  localparam logic [3:0] S_EMIT   = 4'd7;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] nproc_q, nres_q, n, m;
  logic [7:0]       avail_q [MAX_RES];
  logic [7:0]       reqb_q  [MAX_RES];
  logic [WORK_W-1:0] work_q [MAX_RES];
  logic [PID_W-1:0] seq_q   [MAX_PROCS];
  logic [MAX_PROCS-1:0] fin_q;
  logic [CNT_W-1:0] idx_q, done_q;
  logic             prog_q, is_check_q, seqmode_q;
  logic [PID_W-1:0] pid_q, k_q;
  logic [RES_W-1:0] rix_q;
  logic [7:0]       amt_q;
  logic [2:0]       op_q, res_st_q;
  row_t             orig_q, rdata;
  mem_req_t         mreq;
  logic             out_free, accept;

  logic [MAX_RES-1:0] claim_bad, avail_bad, fit_ok;
  logic [8:0]         need [MAX_RES];

  assign n = clamp_cnt(nproc_q);
  assign m = clamp_cnt(nres_q);
  assign cfg_ready_o = 1'b1;
  assign in_stall_o = (state_q != S_IDLE);
  assign accept = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_o || !out_stall_i;

  bsrc_row_mem u_mem (.clk_i(clk_i), .req_i(mreq), .rdata_o(rdata));

  always_comb begin
    for (int j = 0; j < MAX_RES; j++) begin
      need[j] = {1'b0, rdata[j].maxc} - {1'b0, rdata[j].alloc};
      claim_bad[j] = (CNT_W'(j) < m) && ($signed({1'b0, reqb_q[j]}) > $signed(need[j]));
      avail_bad[j] = (CNT_W'(j) < m) && (reqb_q[j] > avail_q[j]);
      fit_ok[j]    = (CNT_W'(j) >= m) ||
                     ($signed({{4{need[j][8]}}, need[j]}) <= $signed({1'b0, work_q[j]}));
    end
  end

  always_comb begin
    row_t r;
    r = rdata;
    mreq = '0;
    mreq.wdata = rdata;
    case (state_q)
      S_CLEAR: begin
        mreq.we    = 1'b1;
        mreq.waddr = idx_q[PID_W-1:0];
        mreq.wdata = '0;
      end
      S_IDLE: begin
        mreq.re    = accept;
        mreq.raddr = process_id_i;
      end
      S_WRMOD: begin
        if (op_q == OP_MAX) r[rix_q].maxc = amt_q;
        else r[rix_q].alloc = amt_q;
        mreq.we    = 1'b1;
        mreq.waddr = pid_q;
        mreq.wdata = r;
      end
      S_REQCHK: begin
        for (int j = 0; j < MAX_RES; j++) begin
          if (CNT_W'(j) < m) r[j].alloc = rdata[j].alloc + reqb_q[j];
        end
        mreq.we    = !(|claim_bad) && !(|avail_bad);
        mreq.waddr = pid_q;
        mreq.wdata = r;
      end
      S_SCRD: begin
        if ((done_q != n) && (idx_q < n) && !fin_q[idx_q[PID_W-1:0]]) begin
          mreq.re    = 1'b1;
          mreq.raddr = idx_q[PID_W-1:0];
        end else if ((done_q != n) && (idx_q >= n) && !prog_q && !is_check_q) begin
          mreq.we    = 1'b1;
          mreq.waddr = pid_q;
          mreq.wdata = orig_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:  if (idx_q == CNT_W'(MAX_PROCS - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (operation_i > OP_CHECK) state_d = S_EMIT;
          else if (operation_i == OP_CHECK) state_d = S_SCINIT;
          else if (({1'b0, resource_index_i} >= m) ||
                   ((operation_i != OP_AVAIL) && ({1'b0, process_id_i} >= n))) state_d = S_EMIT;
          else if ((operation_i == OP_MAX) || (operation_i == OP_ALLOC)) state_d = S_WRMOD;
          else if ((operation_i == OP_REQ) && last_element_i) state_d = S_REQCHK;
          else state_d = S_EMIT;
        end
      end
      S_WRMOD:  state_d = S_EMIT;
      S_REQCHK: state_d = ((|claim_bad) || (|avail_bad)) ? S_EMIT : S_SCINIT;
      S_SCINIT: state_d = S_SCRD;
      S_SCRD: begin
        if (done_q == n) state_d = S_EMIT;
        else if (idx_q >= n) state_d = prog_q ? S_SCRD : S_EMIT;
        else if (!fin_q[idx_q[PID_W-1:0]]) state_d = S_SCEV;
      end
      S_SCEV:   state_d = S_SCRD;
      S_EMIT: begin
        if (out_free && (!seqmode_q || ({1'b0, k_q} + CNT_W'(1) == n))) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      nproc_q     <= CNT_W'(8);
      nres_q      <= CNT_W'(8);
      fin_q       <= '0;
      idx_q       <= '0;
      done_q      <= '0;
      prog_q      <= 1'b0;
      is_check_q  <= 1'b0;
      seqmode_q   <= 1'b0;
      k_q         <= '0;
      out_valid_o <= 1'b0;
      for (int j = 0; j < MAX_RES; j++) begin
        avail_q[j] <= '0;
        reqb_q[j]  <= '0;
        work_q[j]  <= '0;
      end
      for (int i = 0; i < MAX_PROCS; i++) seq_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_PROCS) nproc_q <= cfg_data_i;
        else nres_q <= cfg_data_i;
      end
      if (out_valid_o && !out_stall_i && (state_q != S_EMIT)) out_valid_o <= 1'b0;
      case (state_q)
        S_CLEAR: idx_q <= idx_q + CNT_W'(1);
        S_IDLE: begin
          if (accept) begin
            op_q      <= operation_i;
            pid_q     <= process_id_i;
            rix_q     <= resource_index_i;
            amt_q     <= amount_i;
            seqmode_q <= 1'b0;
            k_q       <= '0;
            is_check_q <= (operation_i == OP_CHECK);
            if (state_d == S_EMIT && ((operation_i > OP_CHECK) ||
                ({1'b0, resource_index_i} >= m) ||
                ((operation_i != OP_AVAIL) && ({1'b0, process_id_i} >= n)))) begin
              res_st_q <= ST_BAD;
            end else begin
              res_st_q <= ST_WRITTEN;
              if (operation_i == OP_AVAIL) begin
                avail_q[resource_index_i] <= amount_i;
              end else if (operation_i == OP_REQ) begin
                reqb_q[resource_index_i] <= amount_i;
              end
            end
          end
        end
        S_REQCHK: begin
          orig_q <= rdata;
          if (|claim_bad) res_st_q <= ST_CLAIM;
          else if (|avail_bad) res_st_q <= ST_UNAVAIL;
          else begin
            for (int j = 0; j < MAX_RES; j++) begin
              if (CNT_W'(j) < m) avail_q[j] <= avail_q[j] - reqb_q[j];
            end
          end
          if ((|claim_bad) || (|avail_bad)) begin
            for (int j = 0; j < MAX_RES; j++) reqb_q[j] <= '0;
          end
        end
        S_SCINIT: begin
          for (int j = 0; j < MAX_RES; j++) begin
            work_q[j] <= (CNT_W'(j) < m) ? {4'b0, avail_q[j]} : '0;
          end
          fin_q  <= '0;
          idx_q  <= '0;
          done_q <= '0;
          prog_q <= 1'b0;
        end
        S_SCRD: begin
          if (done_q == n || (idx_q >= n && !prog_q)) begin
            if (is_check_q) begin
              seqmode_q <= (done_q == n);
              res_st_q  <= ST_UNSAFE;
            end else begin
              res_st_q <= (done_q == n) ? ST_GRANTED : ST_DENIED;
              for (int j = 0; j < MAX_RES; j++) begin
                reqb_q[j] <= '0;
                if ((done_q != n) && (CNT_W'(j) < m)) avail_q[j] <= avail_q[j] + reqb_q[j];
              end
            end
          end else if (idx_q >= n) begin
            idx_q  <= '0;
            prog_q <= 1'b0;
          end else if (fin_q[idx_q[PID_W-1:0]]) begin
            idx_q <= idx_q + CNT_W'(1);
          end
        end
        S_SCEV: begin
          if (&fit_ok) begin
            for (int j = 0; j < MAX_RES; j++) begin
              logic [WORK_W:0] s;
              s = {1'b0, work_q[j]} + {5'b0, rdata[j].alloc};
              if (CNT_W'(j) < m) work_q[j] <= s[WORK_W] ? WORK_MAX : s[WORK_W-1:0];
            end
            seq_q[done_q[PID_W-1:0]] <= idx_q[PID_W-1:0];
            fin_q[idx_q[PID_W-1:0]]  <= 1'b1;
            done_q <= done_q + CNT_W'(1);
            prog_q <= 1'b1;
          end
          idx_q <= idx_q + CNT_W'(1);
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_o <= 1'b1;
            if (seqmode_q) begin
              status_o            <= ST_SAFE;
              sequence_process_o  <= seq_q[k_q];
              sequence_position_o <= k_q;
              last_o              <= ({1'b0, k_q} + CNT_W'(1) == n);
              k_q                 <= k_q + PID_W'(1);
            end else begin
              status_o            <= res_st_q;
              sequence_process_o  <= '0;
              sequence_position_o <= '0;
              last_o              <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_fin_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCRD || state_q == S_SCEV) |-> ($countones(fin_q) == 32'(done_q)))
    else $error("finished flags disagree with done count");

  a_done_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCRD) |-> (done_q <= n))
    else $error("scan finished more processes than in use");

  a_seq_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_SAFE) |-> ({1'b0, sequence_position_o} < n))
    else $error("safe sequence position beyond process count");
endmodule

>>> tb/sv/bankers_safety_request_check_unit_test.sv
// Self-checking testbench for the banker's safety request check unit.
`timescale 1ns / 1ps

module bankers_safety_request_check_unit_test
  import bsrc_pkg::*;
;

  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] proc_id;
    logic [2:0] position;
    logic       last;
  } word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [2:0] operation_i = '0;
  logic [2:0] process_id_i = '0;
  logic [2:0] resource_index_i = '0;
  logic [7:0] amount_i = '0;
  logic       last_element_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic [2:0] sequence_process_o;
  logic [2:0] sequence_position_o;
  logic       last_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_index_i = 1'b0;
  logic [3:0] cfg_data_i = '0;

  bankers_safety_request_check_unit uut (.*);

  always #4 clk_i = ~clk_i;

  // Model of the tables held by the unit.
  logic [7:0] avail_q [MAX_RES];
  logic [7:0] claim_q [MAX_PROCS*MAX_RES];
  logic [7:0] alloc_q [MAX_PROCS*MAX_RES];
  int         need_q  [MAX_PROCS*MAX_RES];
  logic [7:0] reqbuf_q [MAX_RES];
  logic [3:0] procs_reg = 4'd8;
  logic [3:0] res_reg = 4'd8;

  word_t expected_words[$];
  int    errors = 0;
  bit    gaps_on = 1'b1;
  bit    long_hold = 1'b0;

  function automatic int procs_in_use();
    return procs_reg == 0 ? 1 : (procs_reg > 8 ? 8 : int'(procs_reg));
  endfunction

  function automatic int res_in_use();
    return res_reg == 0 ? 1 : (res_reg > 8 ? 8 : int'(res_reg));
  endfunction

  function automatic bit safe_order(output logic [2:0] order [MAX_PROCS]);
    int work [MAX_RES];
    logic [7:0] fin;
    int n, m, done, s;
    bit progress, fits;
    n = procs_in_use();
    m = res_in_use();
    done = 0;
    fin = '0;
    for (int j = 0; j < MAX_RES; j++) work[j] = (j < m) ? int'(avail_q[j]) : 0;
    for (int k = 0; k < MAX_PROCS; k++) order[k] = '0;
    while (done < n) begin
      progress = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (fin[i]) continue;
        fits = 1'b1;
        for (int j = 0; j < m; j++) if (need_q[i*MAX_RES+j] > work[j]) fits = 1'b0;
        if (!fits) continue;
        for (int j = 0; j < m; j++) begin
          s = work[j] + int'(alloc_q[i*MAX_RES+j]);
          work[j] = s > int'(WORK_MAX) ? int'(WORK_MAX) : s;
        end
        order[done] = 3'(i);
        fin[i] = 1'b1;
        done++;
        progress = 1'b1;
      end
      if (!progress) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [2:0] judge_request(int p);
    logic [2:0] order [MAX_PROCS];
    int m;
    m = res_in_use();
    for (int j = 0; j < m; j++) if (int'(reqbuf_q[j]) > need_q[p*MAX_RES+j]) return ST_CLAIM;
    for (int j = 0; j < m; j++) if (reqbuf_q[j] > avail_q[j]) return ST_UNAVAIL;
    for (int j = 0; j < m; j++) begin
      avail_q[j] -= reqbuf_q[j];
      alloc_q[p*MAX_RES+j] += reqbuf_q[j];
      need_q[p*MAX_RES+j] -= int'(reqbuf_q[j]);
    end
    if (safe_order(order)) return ST_GRANTED;
    for (int j = 0; j < m; j++) begin
      avail_q[j] += reqbuf_q[j];
      alloc_q[p*MAX_RES+j] -= reqbuf_q[j];
      need_q[p*MAX_RES+j] += int'(reqbuf_q[j]);
    end
    return ST_DENIED;
  endfunction

  function automatic void predict_words(logic [2:0] op, logic [2:0] p, logic [2:0] r,
                                        logic [7:0] amt, logic le);
    logic [2:0] order [MAX_PROCS];
    logic [2:0] st;
    int n, m, idx;
    n = procs_in_use();
    m = res_in_use();
    idx = int'(p) * MAX_RES + int'(r);
    st = ST_WRITTEN;
    if (op > OP_CHECK) begin
      expected_words.push_back('{ST_BAD, 3'd0, 3'd0, 1'b1});
      return;
    end
    if (op == OP_CHECK) begin
      if (!safe_order(order)) expected_words.push_back('{ST_UNSAFE, 3'd0, 3'd0, 1'b1});
      else for (int k = 0; k < n; k++)
        expected_words.push_back('{ST_SAFE, order[k], 3'(k), k + 1 == n});
      return;
    end
    if (int'(r) >= m || (op != OP_AVAIL && int'(p) >= n)) begin
      expected_words.push_back('{ST_BAD, 3'd0, 3'd0, 1'b1});
      return;
    end
    case (op)
      OP_AVAIL: avail_q[r] = amt;
      OP_MAX: begin
        claim_q[idx] = amt;
        need_q[idx] = int'(amt) - int'(alloc_q[idx]);
      end
      OP_ALLOC: begin
        alloc_q[idx] = amt;
        need_q[idx] = int'(claim_q[idx]) - int'(amt);
      end
      default: begin
        reqbuf_q[r] = amt;
        if (le) begin
          st = judge_request(int'(p));
          for (int j = 0; j < MAX_RES; j++) reqbuf_q[j] = '0;
        end
      end
    endcase
    expected_words.push_back('{st, 3'd0, 3'd0, 1'b1});
  endfunction

  task automatic send_word(logic [2:0] op, logic [2:0] p, logic [2:0] r, logic [7:0] amt,
                           logic le);
    int gap;
    gap = gaps_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    process_id_i <= p;
    resource_index_i <= r;
    amount_i <= amt;
    last_element_i <= le;
    do @(posedge clk_i); while (in_stall_o);
    predict_words(op, p, r, amt, le);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [3:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_PROCS) procs_reg = val;
    else res_reg = val;
  endtask

  task automatic send_request(int p, int top);
    int m;
    m = res_in_use();
    for (int j = 0; j < m; j++)
      send_word(OP_REQ, 3'(p), 3'(j), 8'($urandom_range(0, top)), j == m - 1);
  endtask

  task automatic load_tables(int top);
    int n, m, c;
    n = procs_in_use();
    m = res_in_use();
    for (int j = 0; j < m; j++) send_word(OP_AVAIL, 3'd0, 3'(j), 8'($urandom_range(0, top)), 1'b0);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < m; j++) begin
        c = $urandom_range(0, top);
        send_word(OP_MAX, 3'(i), 3'(j), 8'(c), 1'b0);
        send_word(OP_ALLOC, 3'(i), 3'(j), 8'($urandom_range(0, c)), 1'b0);
      end
  endtask

  task automatic send_noise();
    send_word(3'($urandom_range(0, 7)), 3'($urandom), 3'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic test_directed();
    write_reg(CFG_PROCS, 4'd3);
    write_reg(CFG_RES, 4'd2);
    send_word(OP_CHECK, 3'd0, 3'd0, 8'd0, 1'b0);
    send_word(OP_AVAIL, 3'd0, 3'd0, 8'd255, 1'b0);
    send_word(OP_AVAIL, 3'd0, 3'd1, 8'd2, 1'b0);
    send_word(OP_AVAIL, 3'd0, 3'd7, 8'd1, 1'b0);
    send_word(OP_MAX, 3'd7, 3'd0, 8'd1, 1'b0);
    send_word(OP_REQ, 3'd3, 3'd0, 8'd1, 1'b1);
    send_word(OP_SPARE_A, 3'd0, 3'd0, 8'd0, 1'b0);
    send_word(OP_SPARE_B, 3'd1, 3'd1, 8'd1, 1'b1);
    send_word(OP_SPARE_C, 3'd7, 3'd7, 8'd255, 1'b1);
    send_word(OP_MAX, 3'd0, 3'd1, 8'd5, 1'b0);
    send_word(OP_MAX, 3'd1, 3'd1, 8'd9, 1'b0);
    send_word(OP_ALLOC, 3'd1, 3'd1, 8'd3, 1'b0);
    send_word(OP_ALLOC, 3'd2, 3'd0, 8'd255, 1'b0);
    send_word(OP_REQ, 3'd0, 3'd0, 8'd0, 1'b0);
    send_word(OP_REQ, 3'd0, 3'd1, 8'd6, 1'b1);
    send_word(OP_REQ, 3'd0, 3'd1, 8'd4, 1'b1);
    send_word(OP_REQ, 3'd1, 3'd1, 8'd2, 1'b1);
    send_word(OP_CHECK, 3'd0, 3'd0, 8'd0, 1'b0);
    send_word(OP_MAX, 3'd2, 3'd1, 8'd200, 1'b0);
    send_word(OP_CHECK, 3'd0, 3'd0, 8'd0, 1'b0);
    send_word(OP_REQ, 3'd1, 3'd1, 8'd1, 1'b1);
    send_word(OP_ALLOC, 3'd2, 3'd0, 8'd0, 1'b0);
    send_word(OP_CHECK, 3'd0, 3'd0, 8'd0, 1'b0);
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_PROCS, 4'd0);
    write_reg(CFG_RES, 4'd0);
    repeat (6) send_noise();
    send_word(OP_CHECK, 3'd0, 3'd0, 8'd0, 1'b0);
    write_reg(CFG_PROCS, 4'd15);
    write_reg(CFG_RES, 4'd15);
    repeat (6) send_noise();
    send_word(OP_CHECK, 3'd0, 3'd0, 8'd0, 1'b0);
    write_reg(CFG_PROCS, 4'd8);
    write_reg(CFG_RES, 4'd8);
  endtask

  task automatic test_random_scenarios();
    for (int s = 0; s < 7; s++) begin
      write_reg(CFG_PROCS, 4'($urandom_range(1, 8)));
      write_reg(CFG_RES, 4'($urandom_range(1, 4)));
      gaps_on = (s % 4) != 3;
      load_tables(s % 3 == 0 ? 255 : 12);
      repeat (4) begin
        send_request($urandom_range(0, procs_in_use() - 1), $urandom_range(1, 4));
        if ($urandom_range(0, 2) == 0) send_word(OP_CHECK, 3'($urandom), 3'($urandom), 8'd0,
                                                 1'b0);
        if ($urandom_range(0, 3) == 0) send_noise();
      end
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_backpressure();
    write_reg(CFG_PROCS, 4'd8);
    write_reg(CFG_RES, 4'd2);
    long_hold = 1'b1;
    repeat (12) send_word(OP_CHECK, 3'd0, 3'd0, 8'd0, 1'b0);
    drain();
    repeat (10) send_noise();
  endtask

  initial begin
    for (int j = 0; j < MAX_RES; j++) begin
      avail_q[j] = '0;
      reqbuf_q[j] = '0;
    end
    for (int i = 0; i < MAX_PROCS*MAX_RES; i++) begin
      claim_q[i] = '0;
      alloc_q[i] = '0;
      need_q[i] = 0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_extremes();
    test_random_scenarios();
    test_backpressure();
    drain();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_words.size() == 0)
      $display("bankers_safety_request_check_unit_test: clean");
    else
      $display("bankers_safety_request_check_unit_test: errors");
    $finish;
  end

  initial begin
    word_t want;
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = gaps_on ? $urandom_range(0, 17) : 0;
      if (long_hold) begin
        gap = 400;
        long_hold = 1'b0;
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      if (expected_words.size() == 0) begin
        $error("unexpected word: status %0d", status_o);
        errors++;
      end else begin
        want = expected_words.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          errors++;
        end
        if (sequence_process_o !== want.proc_id) begin
          $error("sequence_process: expected %0d, got %0d", want.proc_id, sequence_process_o);
          errors++;
        end
        if (sequence_position_o !== want.position) begin
          $error("sequence_position: expected %0d, got %0d", want.position,
                 sequence_position_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #30ms;
    $display("bankers_safety_request_check_unit_test: errors");
    $finish;
  end

endmodule

>>> bankers_safety_request_check_unit.f
hdl/bsrc_pkg.sv
hdl/bsrc_row_mem.sv
hdl/bankers_safety_request_check_unit.sv
tb/sv/bankers_safety_request_check_unit_test.sv
